>>> rtl/core/delayed_pump_switch_controller_defines.svh
// Assertion macros for the checker file of the pump switch controller.
`ifndef DELAYED_PUMP_SWITCH_CONTROLLER_DEFINES_SVH
`define DELAYED_PUMP_SWITCH_CONTROLLER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define DPSC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pump switch controller check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define DPSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pump switch controller check failed");

`endif

>>> rtl/core/dpsc_pkg.sv
package dpsc_pkg;

    localparam int unsigned TIMER_W   = 16;
    localparam int unsigned CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_DELAY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_RUN   = 2'd2;

    // Register values after reset, in seconds.
    localparam logic [TIMER_W-1:0] STOP_DELAY_RST  = 16'd300;
    localparam logic [TIMER_W-1:0] START_DELAY_RST = 16'd6;
    localparam logic [TIMER_W-1:0] FORCE_RUN_RST   = 16'd1800;

    // Input item kinds.
    localparam logic MODE_TICK    = 1'b0;
    localparam logic MODE_COMMAND = 1'b1;

    typedef struct packed {
        logic mode;
        logic want_on;
        logic forced;
    } in_word_t;

    typedef struct packed {
        logic pump_running;
        logic force_active;
        logic start_pending;
        logic stop_pending;
    } out_word_t;

endpackage

>>> rtl/core/delayed_pump_switch_controller.sv
// Delayed pump switch controller: start delay, stop delay and forced-run limit timers.
// Result words are registered in the output or, on a stall, the skid register.
// Throughput: one input word per cycle while the skid register is empty; the two-entry
// output buffer (output register plus skid register) takes one more word on a stall.
// Reset (rst_n low, asynchronous): pump off, all timers idle, no result words pending,
// and the delay registers return to 300, 6 and 1800 seconds.
module delayed_pump_switch_controller (
    input  logic                                      clk,
    input  logic                                      rst_n,
    // Configuration write port.
    input  logic                                      cfg_we,
    input  logic [dpsc_pkg::CFG_IDX_W-1:0]            cfg_addr,
    input  logic [dpsc_pkg::TIMER_W-1:0]              cfg_wdata,
    // Input channel: ticks and commands.
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  dpsc_pkg::in_word_t                        in_data,
    // Output channel: pump and timer status after each input word.
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output dpsc_pkg::out_word_t                       out_data
);

    // Configuration registers. A new value only matters at the next timer restart,
    // so a running count never sees a write.
    logic [dpsc_pkg::TIMER_W-1:0] stop_delay_reg;
    logic [dpsc_pkg::TIMER_W-1:0] start_delay_reg;
    logic [dpsc_pkg::TIMER_W-1:0] force_run_reg;

    // Controller state.
    logic                         pump_on_reg,       pump_on_next;
    logic [dpsc_pkg::TIMER_W-1:0] start_left_reg,    start_left_next;
    logic                         start_running_reg, start_running_next;
    logic [dpsc_pkg::TIMER_W-1:0] stop_left_reg,     stop_left_next;
    logic                         stop_running_reg,  stop_running_next;
    logic [dpsc_pkg::TIMER_W-1:0] force_left_reg,    force_left_next;
    logic                         force_running_reg, force_running_next;

    // Output buffer: the output register feeds the port, the skid register catches
    // a word accepted in the cycle the output register stalls.
    logic                out_valid_reg;
    dpsc_pkg::out_word_t out_data_reg;
    logic                skid_valid_reg;
    dpsc_pkg::out_word_t skid_data_reg;

    logic                in_accept;
    logic                out_take;
    dpsc_pkg::out_word_t result;

    assign in_ready  = !skid_valid_reg;
    assign in_accept = in_valid && in_ready;
    assign out_take  = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_delay_reg  <= dpsc_pkg::STOP_DELAY_RST;
            start_delay_reg <= dpsc_pkg::START_DELAY_RST;
            force_run_reg   <= dpsc_pkg::FORCE_RUN_RST;
        end
        else if (cfg_we)
        begin
            // The unused index falls through and the write is dropped.
            if (cfg_addr == dpsc_pkg::CFG_STOP_DELAY)
            begin
                stop_delay_reg <= cfg_wdata;
            end
            if (cfg_addr == dpsc_pkg::CFG_START_DELAY)
            begin
                start_delay_reg <= cfg_wdata;
            end
            if (cfg_addr == dpsc_pkg::CFG_FORCE_RUN)
            begin
                force_run_reg <= cfg_wdata;
            end
        end
    end

    // Next state for one input word. On a tick every running timer counts down;
    // one with one or zero seconds left expires. Expiries are applied start, stop,
    // force, so a stop or force expiry wins over a start expiry on the same tick.
    always_comb
    begin
        pump_on_next       = pump_on_reg;
        start_left_next    = start_left_reg;
        start_running_next = start_running_reg;
        stop_left_next     = stop_left_reg;
        stop_running_next  = stop_running_reg;
        force_left_next    = force_left_reg;
        force_running_next = force_running_reg;

        if (in_data.mode == dpsc_pkg::MODE_TICK)
        begin
            if (start_running_reg)
            begin
                if (start_left_reg <= 16'd1)
                begin
                    start_left_next    = '0;
                    start_running_next = 1'b0;
                    pump_on_next       = 1'b1;
                end
                else
                begin
                    start_left_next = start_left_reg - 16'd1;
                end
            end
            if (stop_running_reg)
            begin
                if (stop_left_reg <= 16'd1)
                begin
                    stop_left_next    = '0;
                    stop_running_next = 1'b0;
                    pump_on_next      = 1'b0;
                end
                else
                begin
                    stop_left_next = stop_left_reg - 16'd1;
                end
            end
            if (force_running_reg)
            begin
                if (force_left_reg <= 16'd1)
                begin
                    force_left_next    = '0;
                    force_running_next = 1'b0;
                    pump_on_next       = 1'b0;
                end
                else
                begin
                    force_left_next = force_left_reg - 16'd1;
                end
            end
        end
        else if (in_data.want_on)
        begin
            if (in_data.forced)
            begin
                // Forced on runs the pump at once, unless it already runs.
                if (!pump_on_reg)
                begin
                    stop_running_next  = 1'b0;
                    stop_left_next     = '0;
                    force_left_next    = force_run_reg;
                    force_running_next = 1'b1;
                    pump_on_next       = 1'b1;
                end
            end
            else
            begin
                // Normal on cancels any stop or forced run and restarts the start delay.
                stop_running_next  = 1'b0;
                stop_left_next     = '0;
                force_running_next = 1'b0;
                force_left_next    = '0;
                start_left_next    = start_delay_reg;
                start_running_next = 1'b1;
            end
        end
        else
        begin
            if (in_data.forced)
            begin
                // Forced off only ends a forced run.
                if (force_running_reg)
                begin
                    force_running_next = 1'b0;
                    force_left_next    = '0;
                    pump_on_next       = 1'b0;
                end
            end
            else if (!force_running_reg)
            begin
                // Normal off is locked out during a forced run.
                start_running_next = 1'b0;
                start_left_next    = '0;
                stop_left_next     = stop_delay_reg;
                stop_running_next  = 1'b1;
            end
        end

        result.pump_running  = pump_on_next;
        result.force_active  = force_running_next;
        result.start_pending = start_running_next;
        result.stop_pending  = stop_running_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pump_on_reg       <= 1'b0;
            start_left_reg    <= '0;
            start_running_reg <= 1'b0;
            stop_left_reg     <= '0;
            stop_running_reg  <= 1'b0;
            force_left_reg    <= '0;
            force_running_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            pump_on_reg       <= pump_on_next;
            start_left_reg    <= start_left_next;
            start_running_reg <= start_running_next;
            stop_left_reg     <= stop_left_next;
            stop_running_reg  <= stop_running_next;
            force_left_reg    <= force_left_next;
            force_running_reg <= force_running_next;
        end
    end

    // Output buffer control. A new word goes straight to the output register when
    // that register is free or being emptied this cycle; otherwise it parks in the
    // skid register, which closes the input until the output drains it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            if (!out_valid_reg || out_ready)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            if (!out_valid_reg || out_ready)
            begin
                out_data_reg <= result;
            end
            else
            begin
                skid_data_reg <= result;
            end
        end
        else if (out_take && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
    end

endmodule

>>> rtl/core/dpsc_checker.sv
`include "delayed_pump_switch_controller_defines.svh"

module dpsc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input dpsc_pkg::out_word_t out_data
);

    // A stalled result word holds its value.
    `DPSC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

    // The input only closes when a word already waits at the output.
    `DPSC_ASSERT_NOW(a_ready_low_means_full, !in_ready, out_valid)

    // A forced run always has the pump on, and no stop delay runs beside it.
    `DPSC_ASSERT_NOW(a_force_runs_pump, out_valid && out_data.force_active,
        out_data.pump_running && !out_data.stop_pending)

    // The start and stop delays cancel each other, so they never count together.
    `DPSC_ASSERT_NOW(a_delays_exclusive, out_valid,
        !(out_data.start_pending && out_data.stop_pending))

endmodule

bind delayed_pump_switch_controller dpsc_checker u_dpsc_checker (.*);
